@@ sv/uv_sphere_mesh_point_core_defines.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the UV sphere mesh point core
// ---------------------------------------------------------------------------
`ifndef UV_SPHERE_MESH_POINT_CORE_DEFINES_SVH
`define UV_SPHERE_MESH_POINT_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define USMP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define USMP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/usmp_pkg.sv @@
// ---------------------------------------------------------------------------
// usmp_pkg
// Shared types and constants of the UV sphere mesh point core.
// ---------------------------------------------------------------------------
package usmp_pkg;

  localparam int unsigned MAX_DIVISIONS = 255;
  localparam int unsigned MIN_SECTORS   = 3;
  localparam int unsigned MIN_STACKS    = 2;

  localparam logic [7:0]  SECTOR_RESET = 8'd64;
  localparam logic [7:0]  STACK_RESET  = 8'd32;
  localparam logic [15:0] RADIUS_RESET = 16'd256;

  // Quarter-wave sine polynomial coefficients
  localparam logic [15:0] SIN_A = 16'd51472;
  localparam logic [14:0] SIN_B = 15'd21024;
  localparam logic [11:0] SIN_C = 12'd2320;

  // Phase offset of a quarter turn (cosine from sine)
  localparam logic [15:0] QUARTER_TURN = 16'd16384;

  localparam int unsigned SINE_LATENCY = 4;

  typedef enum logic [1:0] {
    REG_SECTOR_COUNT = 2'd0,
    REG_STACK_COUNT  = 2'd1,
    REG_SPHERE_RADIUS = 2'd2,
    REG_UNUSED       = 2'd3
  } reg_index_t;

  typedef enum logic {
    KIND_VERTEX   = 1'b0,
    KIND_TRIANGLE = 1'b1
  } item_kind_t;

  // Side data traveling next to the sine pipelines
  typedef struct packed {
    logic        vld;
    logic        err;
    logic        has_upper;
    logic        has_lower;
    logic [15:0] k1;
  } side_t;

  function automatic logic [7:0] clamp_count(input logic [7:0] v, input logic [7:0] lo);
    logic [7:0] r;
    r = v;
    if (r < lo) r = lo;
    if (32'(r) > MAX_DIVISIONS) r = 8'(MAX_DIVISIONS);
    return r;
  endfunction

endpackage

@@ sv/usmp_recip.sv @@
// ---------------------------------------------------------------------------
// usmp_recip
// Bit-serial reciprocal: recip = floor(2^32 / divisor), one quotient bit
// per cycle.
// ---------------------------------------------------------------------------
module usmp_recip
  import usmp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [7:0]  divisor,
  output logic        busy,
  output logic [31:0] recip
);

  logic [7:0]  dvs;
  logic [8:0]  rem;
  logic [5:0]  cnt;
  logic [9:0]  rem_shift;
  logic        qbit;

  // The dividend is a single one followed by 32 zeros.
  assign rem_shift = {rem, (cnt == 6'd0)};
  assign qbit      = (rem_shift >= {2'b00, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 6'd1;
      if (cnt == 6'd32) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvs <= divisor;
      rem <= '0;
    end else if (busy) begin
      rem   <= qbit ? 9'(rem_shift - {2'b00, dvs}) : rem_shift[8:0];
      recip <= {recip[30:0], qbit};
    end
  end

endmodule

@@ sv/usmp_sine.sv @@
// ---------------------------------------------------------------------------
// usmp_sine
// Four-stage sine of a 16-bit phase: Q15 magnitude and sign flag.
// ---------------------------------------------------------------------------
module usmp_sine
  import usmp_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [15:0] phase,
  output logic [16:0] mag,
  output logic        neg
);

  logic [15:0] x_in;
  logic [31:0] sq;
  logic [15:0] x_a, x_b, x_c;
  logic [15:0] x2_a, x2_b;
  logic        h_a, h_b, h_c;
  logic [14:0] t_b;
  logic [27:0] ct_prod;
  logic [30:0] xt_prod;
  logic [15:0] u_c;
  logic [31:0] xu_prod;
  logic [16:0] mag_d;

  always_comb begin
    x_in = {phase[13:0], 1'b0};
    if (phase[14]) x_in = 16'd32768 - x_in;
  end

  assign sq      = x_in * x_in;
  assign ct_prod = SIN_C * x2_a;
  assign xt_prod = x2_b * t_b;
  assign xu_prod = x_c * u_c;
  assign mag_d   = xu_prod[31:15];

  always_ff @(posedge clk) begin
    if (en) begin
      x_a  <= x_in;
      x2_a <= sq[30:15];
      h_a  <= phase[15];
      x_b  <= x_a;
      x2_b <= x2_a;
      h_b  <= h_a;
      t_b  <= SIN_B - 15'(ct_prod[27:15]);
      x_c  <= x_b;
      h_c  <= h_b;
      u_c  <= SIN_A - xt_prod[30:15];
      mag  <= mag_d;
      neg  <= h_c && (mag_d != '0);
    end
  end

endmodule

@@ sv/uv_sphere_mesh_point_core.sv @@
// ---------------------------------------------------------------------------
// uv_sphere_mesh_point_core
// One UV sphere grid point in, its Q8.8 vertex and quad triangles out.
// ---------------------------------------------------------------------------
//  channel | handshake              | payload
//  in      | in_valid / in_stall    | stack_index, sector_index
//  out     | out_valid / out_stall  | item_kind, coord_x/y/z, corner_a/b/c,
//          |                        | grid_error, last_of_run
//  cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// A point passes nine register stages, then up to three results leave one
// per cycle while out_stall is low; the stages upstream hold until the
// last result of a point leaves. After reset and after each config write,
// two bit-serial reciprocal units run while in_stall stays high.
// out_stall freezes the whole pipeline once the result holder is full.
`include "uv_sphere_mesh_point_core_defines.svh"

module uv_sphere_mesh_point_core
  import usmp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  stack_index,
  input  logic [7:0]  sector_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        item_kind,
  output logic signed [16:0] coord_x,
  output logic signed [16:0] coord_y,
  output logic signed [16:0] coord_z,
  output logic [15:0] corner_a,
  output logic [15:0] corner_b,
  output logic [15:0] corner_c,
  output logic        grid_error,
  output logic        last_of_run,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [7:0]  sector_count, stack_count;
  logic [15:0] sphere_radius;
  logic [7:0]  ns, st;
  logic        dirty, busy_s, busy_n, recip_start;
  logic [31:0] recip_s, recip_n;
  logic        cfg_wr, accept, en;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign ns        = clamp_count(sector_count, 8'(MIN_SECTORS));
  assign st        = clamp_count(stack_count, 8'(MIN_STACKS));

  always_ff @(posedge clk) begin
    if (rst) begin
      sector_count  <= SECTOR_RESET;
      stack_count   <= STACK_RESET;
      sphere_radius <= RADIUS_RESET;
    end else if (cfg_wr) begin
      unique case (reg_index_t'(cfg_index))
        REG_SECTOR_COUNT:  sector_count  <= cfg_data[7:0];
        REG_STACK_COUNT:   stack_count   <= cfg_data[7:0];
        REG_SPHERE_RADIUS: sphere_radius <= cfg_data;
        default: ;
      endcase
    end
  end

  // Recompute reciprocals whenever the counts may have changed.
  assign recip_start = dirty && !busy_s && !busy_n;

  always_ff @(posedge clk) begin
    if (rst) begin
      dirty <= 1'b1;
    end else if (cfg_wr) begin
      dirty <= 1'b1;
    end else if (recip_start) begin
      dirty <= 1'b0;
    end
  end

  usmp_recip u_recip_s (
    .clk(clk), .rst(rst), .start(recip_start), .divisor(st),
    .busy(busy_s), .recip(recip_s)
  );

  usmp_recip u_recip_n (
    .clk(clk), .rst(rst), .start(recip_start), .divisor(ns),
    .busy(busy_n), .recip(recip_n)
  );

  assign in_stall = dirty || busy_s || busy_n || !en;
  assign accept   = in_valid && !in_stall;

  // ---- stage 1: phase estimate by reciprocal multiply
  logic [22:0] num_s_d;
  logic [23:0] num_n_d;
  logic [54:0] est_s;
  logic [55:0] est_n;
  logic        v1;
  logic [7:0]  i1, j1;
  logic [22:0] num_s1;
  logic [23:0] num_n1;
  logic [16:0] q_s1, q_n1;

  assign num_s_d = {stack_index, 15'd0} + 23'(st[7:1]);
  assign num_n_d = {sector_index, 16'd0} + 24'(ns[7:1]);
  assign est_s   = num_s_d * recip_s;
  assign est_n   = num_n_d * recip_n;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= accept;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      i1     <= stack_index;
      j1     <= sector_index;
      num_s1 <= num_s_d;
      num_n1 <= num_n_d;
      q_s1   <= est_s[48:32];
      q_n1   <= est_n[48:32];
    end
  end

  // ---- stage 2: one-step correction, grid flags, vertex index
  logic [24:0] rem_s, rem_n;
  logic [16:0] ps_full, pt_full;
  logic [15:0] ps2, pt2, ps2_cos, pt2_cos;
  side_t       side_d, side2;
  logic        inner;

  assign rem_s   = 25'(num_s1) - 25'(q_s1) * 25'(st);
  assign rem_n   = 25'(num_n1) - 25'(q_n1) * 25'(ns);
  assign ps_full = (rem_s >= 25'(st)) ? q_s1 + 17'd1 : q_s1;
  assign pt_full = (rem_n >= 25'(ns)) ? q_n1 + 17'd1 : q_n1;
  assign inner   = (i1 < st) && (j1 < ns);

  always_comb begin
    side_d.vld       = v1;
    side_d.err       = (i1 > st) || (j1 > ns);
    side_d.has_upper = inner && (i1 != 8'd0);
    side_d.has_lower = inner && (i1 != st - 8'd1);
    side_d.k1        = 16'(i1) * (16'(ns) + 16'd1) + 16'(j1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side2.vld <= 1'b0;
    end else if (en) begin
      side2 <= side_d;
      ps2   <= ps_full[15:0];
      pt2   <= pt_full[15:0];
    end
  end

  assign ps2_cos = ps2 + QUARTER_TURN;
  assign pt2_cos = pt2 + QUARTER_TURN;

  // ---- stages 3-6: sines
  logic [16:0] cs, ss, ct, sn;
  logic        ncs, nss, nct, nsn;

  usmp_sine u_sin_cs (.clk(clk), .en(en), .phase(ps2),     .mag(cs), .neg(ncs));
  usmp_sine u_sin_ss (.clk(clk), .en(en), .phase(ps2_cos), .mag(ss), .neg(nss));
  usmp_sine u_sin_ct (.clk(clk), .en(en), .phase(pt2_cos), .mag(ct), .neg(nct));
  usmp_sine u_sin_sn (.clk(clk), .en(en), .phase(pt2),     .mag(sn), .neg(nsn));

  side_t side_dly [SINE_LATENCY];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < SINE_LATENCY; k++) side_dly[k].vld <= 1'b0;
    end else if (en) begin
      side_dly[0] <= side2;
      for (int k = 1; k < SINE_LATENCY; k++) side_dly[k] <= side_dly[k-1];
    end
  end

  // ---- stage 7: angle products and y
  side_t       side7;
  logic [33:0] cc_x_d, cc_z_d;
  logic [30:0] cc_x7, cc_z7;
  logic [32:0] y_prod7;
  logic        neg_x7, neg_z7, neg_y7;

  assign cc_x_d = cs * ct;
  assign cc_z_d = cs * sn;

  always_ff @(posedge clk) begin
    if (rst) begin
      side7.vld <= 1'b0;
    end else if (en) begin
      side7   <= side_dly[SINE_LATENCY-1];
      cc_x7   <= cc_x_d[30:0];
      cc_z7   <= cc_z_d[30:0];
      y_prod7 <= sphere_radius * ss;
      neg_x7  <= (ncs != nct) && (cs != '0) && (ct != '0);
      neg_z7  <= (ncs != nsn) && (cs != '0) && (sn != '0);
      neg_y7  <= nss;
    end
  end

  // ---- stage 8: radius scale, rounding, saturation
  logic [46:0] xp, zp;
  logic [47:0] xr, zr;
  logic [33:0] yr;
  side_t       side8;
  logic [16:0] x8, y8, z8;

  assign xp = sphere_radius * cc_x7;
  assign zp = sphere_radius * cc_z7;
  assign xr = {1'b0, xp} + 48'(1 << 29);
  assign zr = {1'b0, zp} + 48'(1 << 29);
  assign yr = {1'b0, y_prod7} + 34'(1 << 14);

  function automatic logic [16:0] pack_coord(input logic [17:0] m, input logic n);
    logic [16:0] s;
    s = (m > 18'd65535) ? 17'd65535 : m[16:0];
    return n ? 17'(17'd0 - s) : s;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      side8.vld <= 1'b0;
    end else if (en) begin
      side8 <= side7;
      x8 <= pack_coord(xr[47:30], neg_x7);
      z8 <= pack_coord(zr[47:30], neg_z7);
      y8 <= pack_coord({1'b0, yr[33:15]} > 20'd65535 ? 18'd65535 : 18'(yr[33:15]), neg_y7);
    end
  end

  // ---- result holder: sequences up to three results per point
  logic        pend_v, pend_u, pend_l, h_err;
  logic [16:0] hx, hy, hz;
  logic [15:0] hk1, hk2;
  logic        hv, o_free, emit, h_last;

  assign hv     = pend_v || pend_u || pend_l;
  assign o_free = !out_valid || !out_stall;
  assign emit   = hv && o_free;
  assign h_last = ($countones({pend_v, pend_u, pend_l}) == 1);
  assign en     = !hv || (emit && h_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_v <= 1'b0;
      pend_u <= 1'b0;
      pend_l <= 1'b0;
    end else if (en) begin
      pend_v <= side8.vld;
      pend_u <= side8.vld && !side8.err && side8.has_upper;
      pend_l <= side8.vld && !side8.err && side8.has_lower;
    end else if (emit) begin
      priority if (pend_v) pend_v <= 1'b0;
      else if (pend_u) pend_u <= 1'b0;
      else pend_l <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h_err <= side8.err;
      hx    <= x8;
      hy    <= y8;
      hz    <= z8;
      hk1   <= side8.k1;
      hk2   <= side8.k1 + 16'(ns) + 16'd1;
    end
  end

  // ---- output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (o_free) out_valid <= emit;
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      last_of_run <= h_last;
      grid_error  <= pend_v && h_err;
      priority if (pend_v) begin
        item_kind <= KIND_VERTEX;
        coord_x   <= h_err ? '0 : hx;
        coord_y   <= h_err ? '0 : hy;
        coord_z   <= h_err ? '0 : hz;
        corner_a  <= '0;
        corner_b  <= '0;
        corner_c  <= '0;
      end else if (pend_u) begin
        item_kind <= KIND_TRIANGLE;
        coord_x   <= '0;
        coord_y   <= '0;
        coord_z   <= '0;
        corner_a  <= hk1;
        corner_b  <= hk2;
        corner_c  <= hk1 + 16'd1;
      end else begin
        item_kind <= KIND_TRIANGLE;
        coord_x   <= '0;
        coord_y   <= '0;
        coord_z   <= '0;
        corner_a  <= hk1 + 16'd1;
        corner_b  <= hk2;
        corner_c  <= hk2 + 16'd1;
      end
    end
  end

  `USMP_ASSERT_NOW(a_no_accept_in_refresh, accept, !busy_s && !busy_n && !dirty, "accept during reciprocal refresh")
  `USMP_ASSERT_NOW(a_err_is_last, out_valid && grid_error, last_of_run && item_kind == KIND_VERTEX, "error result not single vertex")
  `USMP_ASSERT_NEXT(a_pipe_holds, side8.vld && !en, side8.vld, "final stage lost while frozen")
  `USMP_ASSERT_NOW(a_tri_no_err, out_valid && item_kind == KIND_TRIANGLE, !grid_error, "triangle flagged as error")

endmodule
